// File: src/nsf_pkg.sv
// ---------------------------------------------------------------------------
// nsf_pkg: shared types and constants of the NMEA sentence framer
// Byte classes handed from the front end to the sentence engine, verdict and
// sentence type codes, and the type/minimum-field lookup.
// ---------------------------------------------------------------------------
package nsf_pkg;

  // byte classes
  typedef enum logic [2:0] {
    TOK_DATA  = 3'd0,
    TOK_START = 3'd1,
    TOK_CLOSE = 3'd2,
    TOK_STAR  = 3'd3,
    TOK_COMMA = 3'd4
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  data;
    logic        hex_ok;
    logic [3:0]  hex_val;
  } token_t;

  typedef enum logic [2:0] {
    VERD_OK     = 3'd0,
    VERD_FEW    = 3'd1,
    VERD_SHORT  = 3'd2,
    VERD_SUM    = 3'd3,
    VERD_HEADER = 3'd4,
    VERD_TYPE   = 3'd5
  } verdict_e;

  typedef enum logic [3:0] {
    ST_UNKNOWN = 4'd0,
    ST_GGA     = 4'd1,
    ST_RMC     = 4'd2,
    ST_VTG     = 4'd3,
    ST_GSA     = 4'd4,
    ST_GSV     = 4'd5,
    ST_GLL     = 4'd6,
    ST_GST     = 4'd7,
    ST_HDT     = 4'd8,
    ST_THS     = 4'd9,
    ST_ZDA     = 4'd10
  } stype_e;

  typedef struct packed {
    stype_e      code;
    logic [3:0]  min_fields;
  } type_info_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] MIN_LENGTH = 8'd10;
  localparam logic [2:0] HDR_MIN    = 3'd5;

  localparam logic [23:0] TAG_GGA = 24'h474741;
  localparam logic [23:0] TAG_RMC = 24'h524D43;
  localparam logic [23:0] TAG_VTG = 24'h565447;
  localparam logic [23:0] TAG_GSA = 24'h475341;
  localparam logic [23:0] TAG_GSV = 24'h475356;
  localparam logic [23:0] TAG_GLL = 24'h474C4C;
  localparam logic [23:0] TAG_GST = 24'h475354;
  localparam logic [23:0] TAG_HDT = 24'h484454;
  localparam logic [23:0] TAG_THS = 24'h544853;
  localparam logic [23:0] TAG_ZDA = 24'h5A4441;

  // min_fields of zero marks an unrecognized or unsupported type
  function automatic type_info_t type_lookup(logic [23:0] tag);
    type_info_t info;
    info.code       = ST_UNKNOWN;
    info.min_fields = 4'd0;
    unique case (tag)
      TAG_GGA: begin info.code = ST_GGA; info.min_fields = 4'd15; end
      TAG_RMC: begin info.code = ST_RMC; info.min_fields = 4'd12; end
      TAG_VTG: begin info.code = ST_VTG; info.min_fields = 4'd9;  end
      TAG_GSA: info.code = ST_GSA;
      TAG_GSV: info.code = ST_GSV;
      TAG_GLL: info.code = ST_GLL;
      TAG_GST: begin info.code = ST_GST; info.min_fields = 4'd8;  end
      TAG_HDT: begin info.code = ST_HDT; info.min_fields = 4'd2;  end
      TAG_THS: begin info.code = ST_THS; info.min_fields = 4'd3;  end
      TAG_ZDA: begin info.code = ST_ZDA; info.min_fields = 4'd5;  end
      default: info.code = ST_UNKNOWN;
    endcase
    return info;
  endfunction

endpackage

// File: src/nsf_front.sv
// ---------------------------------------------------------------------------
// nsf_front: byte classifier and token queue
// Sorts each received byte into its class, decodes it as a hex digit and
// holds the tokens in a two-entry queue ahead of the sentence engine.
// ---------------------------------------------------------------------------
module nsf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output nsf_pkg::token_t tok_o
);
  import nsf_pkg::*;

  localparam int unsigned Depth = 2;

  token_t                   tok_in;
  token_t                   mem_q [Depth];
  logic [$clog2(Depth)-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [$clog2(Depth):0]   count_q, count_d;
  logic                     push, pop;

  // classify
  always_comb begin
    tok_in.data    = data_byte_i;
    tok_in.hex_ok  = 1'b0;
    tok_in.hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(data_byte_i - 8'h37);
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(data_byte_i - 8'h57);
    end
    if (data_byte_i == CH_DOLLAR || data_byte_i == CH_BANG) begin
      tok_in.kind = TOK_START;
    end else if (data_byte_i == CH_CR || data_byte_i == CH_LF) begin
      tok_in.kind = TOK_CLOSE;
    end else if (data_byte_i == CH_STAR) begin
      tok_in.kind = TOK_STAR;
    end else if (data_byte_i == CH_COMMA) begin
      tok_in.kind = TOK_COMMA;
    end else begin
      tok_in.kind = TOK_DATA;
    end
  end

  assign in_ready_o  = (count_q != ($clog2(Depth)+1)'(Depth));
  assign tok_valid_o = (count_q != '0);
  assign tok_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = tok_valid_o && tok_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ($clog2(Depth)+1)'(Depth))
    else $error("token queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == ($clog2(Depth)+1)'(Depth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("token queue pointers disagree with count");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == ($clog2(Depth)+1)'(Depth) && !pop) |=>
      count_q == ($clog2(Depth)+1)'(Depth))
    else $error("full token queue took a transfer");

endmodule

// File: src/nsf_back.sv
// ---------------------------------------------------------------------------
// nsf_back: sentence engine
// Tracks the open line from the token stream, judges the line on CR or LF
// and holds the verdict in an output register until it is taken.
// ---------------------------------------------------------------------------
module nsf_back #(
  parameter int unsigned MAX_LINE = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  output logic            tok_ready_o,
  input  nsf_pkg::token_t tok_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      verdict_o,
  output logic [3:0]      sentence_type_o,
  output logic [7:0]      field_total_o,
  output logic [7:0]      computed_sum_o,
  output logic [31:0]     parsed_count_o,
  output logic [31:0]     bad_sum_count_o
);
  import nsf_pkg::*;

  // control state
  logic        active_q, active_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] parsed_q, parsed_d;
  logic [31:0] bad_sum_q, bad_sum_d;

  // line state, written on every start token before use
  logic [7:0]  len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic        star_q, star_d;
  logic [1:0]  after_q, after_d;
  logic        hi_ok_q, hi_ok_d, lo_ok_q, lo_ok_d;
  logic [3:0]  hi_val_q, hi_val_d, lo_val_q, lo_val_d;
  logic        in_hdr_q, in_hdr_d;
  logic [2:0]  hdr_len_q, hdr_len_d;
  logic [23:0] tail_q, tail_d;
  logic [7:0]  comma_q, comma_d;

  // result register
  verdict_e    verdict_q, verdict_d;
  stype_e      stype_q, stype_d;
  logic [7:0]  fields_q, fields_d;
  logic [7:0]  sum_q, sum_d;

  logic        closing, pop, sum_ok;
  type_info_t  info;

  assign closing     = tok_valid_i && tok_i.kind == TOK_CLOSE && active_q;
  assign tok_ready_o = !closing || !out_valid_q || out_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign info        = type_lookup(tail_q);

  always_comb begin
    sum_ok = 1'b0;
    if (star_q && after_q == 2'd2 && hi_ok_q) begin
      sum_ok = lo_ok_q ? ({hi_val_q, lo_val_q} == xor_q) : ({4'd0, hi_val_q} == xor_q);
    end
  end

  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_ready_i;
    parsed_d    = parsed_q;
    bad_sum_d   = bad_sum_q;
    len_d       = len_q;
    xor_d       = xor_q;
    star_d      = star_q;
    after_d     = after_q;
    hi_ok_d     = hi_ok_q;
    hi_val_d    = hi_val_q;
    lo_ok_d     = lo_ok_q;
    lo_val_d    = lo_val_q;
    in_hdr_d    = in_hdr_q;
    hdr_len_d   = hdr_len_q;
    tail_d      = tail_q;
    comma_d     = comma_q;
    verdict_d   = verdict_q;
    stype_d     = stype_q;
    fields_d    = fields_q;
    sum_d       = sum_q;
    if (pop) begin
      if (tok_i.kind == TOK_START) begin
        active_d  = 1'b1;
        len_d     = 8'd1;
        xor_d     = 8'd0;
        star_d    = 1'b0;
        after_d   = 2'd0;
        hi_ok_d   = 1'b0;
        lo_ok_d   = 1'b0;
        in_hdr_d  = 1'b1;
        hdr_len_d = 3'd0;
        tail_d    = 24'd0;
        comma_d   = 8'd0;
      end else if (closing) begin
        active_d    = 1'b0;
        out_valid_d = 1'b1;
        stype_d     = ST_UNKNOWN;
        fields_d    = comma_q + 8'd1;
        sum_d       = xor_q;
        if (len_q < MIN_LENGTH) begin
          verdict_d = VERD_SHORT;
        end else if (!sum_ok) begin
          verdict_d = VERD_SUM;
          bad_sum_d = bad_sum_q + 32'd1;
        end else if (hdr_len_q < HDR_MIN) begin
          verdict_d = VERD_HEADER;
        end else begin
          stype_d = info.code;
          if (info.min_fields == 4'd0) begin
            verdict_d = VERD_TYPE;
          end else begin
            parsed_d = parsed_q + 32'd1;
            // field count can reach 256, compare at nine bits
            verdict_d = (({1'b0, comma_q} + 9'd1) < {5'd0, info.min_fields}) ?
                        VERD_FEW : VERD_OK;
          end
        end
      end else if (active_q && tok_i.kind != TOK_CLOSE) begin
        if (len_q >= 8'(MAX_LINE)) begin
          // overflow drops the line without a result
          active_d = 1'b0;
        end else begin
          len_d = len_q + 8'd1;
          if (star_q) begin
            if (after_q == 2'd0) begin
              hi_ok_d  = tok_i.hex_ok;
              hi_val_d = tok_i.hex_val;
            end else if (after_q == 2'd1) begin
              lo_ok_d  = tok_i.hex_ok;
              lo_val_d = tok_i.hex_val;
            end
            if (after_q != 2'd2) begin
              after_d = after_q + 2'd1;
            end
          end else if (tok_i.kind == TOK_STAR) begin
            star_d   = 1'b1;
            in_hdr_d = 1'b0;
          end else begin
            xor_d = xor_q ^ tok_i.data;
            if (tok_i.kind == TOK_COMMA) begin
              comma_d  = comma_q + 8'd1;
              in_hdr_d = 1'b0;
            end else if (in_hdr_q) begin
              if (hdr_len_q < HDR_MIN) begin
                hdr_len_d = hdr_len_q + 3'd1;
              end
              tail_d = {tail_q[15:0], tok_i.data};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      parsed_q    <= 32'd0;
      bad_sum_q   <= 32'd0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      parsed_q    <= parsed_d;
      bad_sum_q   <= bad_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    xor_q     <= xor_d;
    star_q    <= star_d;
    after_q   <= after_d;
    hi_ok_q   <= hi_ok_d;
    hi_val_q  <= hi_val_d;
    lo_ok_q   <= lo_ok_d;
    lo_val_q  <= lo_val_d;
    in_hdr_q  <= in_hdr_d;
    hdr_len_q <= hdr_len_d;
    tail_q    <= tail_d;
    comma_q   <= comma_d;
    verdict_q <= verdict_d;
    stype_q   <= stype_d;
    fields_q  <= fields_d;
    sum_q     <= sum_d;
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign sentence_type_o = stype_q;
  assign field_total_o   = fields_q;
  assign computed_sum_o  = sum_q;
  assign parsed_count_o  = parsed_q;
  assign bad_sum_count_o = bad_sum_q;

  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && closing) |=> out_valid_q)
    else $error("closed line produced no result");

  a_bad_sum_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bad_sum_q != $past(bad_sum_q)) |-> (out_valid_q && verdict_q == VERD_SUM))
    else $error("checksum error count moved without a checksum verdict");

  a_no_close_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && closing) |-> !tok_ready_o)
    else $error("close taken while result register is occupied");

endmodule

// File: src/nmea_sentence_framer.sv
// throughput: one byte per cycle while the two-entry token queue has room; the sentence engine
//   stalls only on a line close while a result waits to be taken, so only then does the queue fill
// reset: rst_ni asynchronous, active low; closes any open line and clears both counters
// ---------------------------------------------------------------------------
// nmea_sentence_framer: NMEA 0183 sentence framer and checksum checker
// Takes the received byte stream, frames sentences between a start byte and
// CR or LF, and reports one verdict with running counts per closed line.
// ---------------------------------------------------------------------------
module nmea_sentence_framer #(
  parameter int unsigned MAX_LINE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [3:0]  sentence_type_o,
  output logic [7:0]  field_total_o,
  output logic [7:0]  computed_sum_o,
  output logic [31:0] parsed_count_o,
  output logic [31:0] bad_sum_count_o
);
  import nsf_pkg::*;

  token_t tok;
  logic   tok_valid, tok_ready;

  nsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .tok_valid_o (tok_valid),
    .tok_ready_i (tok_ready),
    .tok_o       (tok)
  );

  nsf_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (tok_valid),
    .tok_ready_o     (tok_ready),
    .tok_i           (tok),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o),
    .sentence_type_o (sentence_type_o),
    .field_total_o   (field_total_o),
    .computed_sum_o  (computed_sum_o),
    .parsed_count_o  (parsed_count_o),
    .bad_sum_count_o (bad_sum_count_o)
  );

endmodule
